FILE: design/mord_pkg.sv
// mord_pkg: shared types, constants and tables for the multilevel ordered dither block
// no dependencies; imported by mord_recip, mord_chan and multilevel_ordered_dither_rgb
package mord_pkg;

  localparam int MATRIX_SIZE = 8;
  localparam int PIX_W       = 8;
  localparam int LEVELS_W    = 9;
  localparam int TH_W        = 6;
  localparam int PHASE_W     = 3;

  // reciprocal format: floor(2^RCP_SHIFT / m) + 1, exact floor for numerators below 2^16
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = 25;

  // reciprocal of the constant 255 in the same format
  localparam int K255_W = 17;
  localparam logic [K255_W-1:0] K255 = K255_W'((2**RCP_SHIFT) / 255 + 1);

  // cycles from the accepting edge to the result strobe
  localparam int LAT = 8;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } reg_idx_t;

  // one channel's work as it enters the pipeline
  typedef struct packed {
    logic [PIX_W-1:0]    pix;
    logic [LEVELS_W-1:0] levels;
    logic [TH_W-1:0]     th;
  } chan_in_t;

  localparam logic [TH_W-1:0] DMAT [MATRIX_SIZE][MATRIX_SIZE] = '{
    '{6'd0,  6'd24, 6'd36, 6'd60, 6'd2,  6'd26, 6'd38, 6'd62},
    '{6'd44, 6'd52, 6'd8,  6'd16, 6'd46, 6'd54, 6'd10, 6'd18},
    '{6'd28, 6'd4,  6'd56, 6'd32, 6'd30, 6'd6,  6'd58, 6'd34},
    '{6'd48, 6'd40, 6'd20, 6'd12, 6'd50, 6'd42, 6'd22, 6'd14},
    '{6'd3,  6'd27, 6'd39, 6'd63, 6'd1,  6'd25, 6'd37, 6'd61},
    '{6'd47, 6'd55, 6'd11, 6'd19, 6'd45, 6'd53, 6'd9,  6'd17},
    '{6'd31, 6'd7,  6'd59, 6'd35, 6'd29, 6'd5,  6'd57, 6'd33},
    '{6'd51, 6'd43, 6'd23, 6'd15, 6'd49, 6'd41, 6'd21, 6'd13}
  };

endpackage

FILE: design/mord_recip.sv
// mord_recip: constant reciprocal table for 8-bit divisors, built at elaboration
// depends on mord_pkg (RCP_SHIFT, RCP_W)
module mord_recip
  import mord_pkg::*;
(
  input  logic [PIX_W-1:0] idx,
  output logic [RCP_W-1:0] rcp
);

  logic [RCP_W-1:0] tab [2**PIX_W];

  // divisor zero never reaches a used result
  assign tab[0] = '0;

  for (genvar i = 1; i < 2**PIX_W; i++) begin : g_rcp
    localparam int unsigned Rcp = (2**RCP_SHIFT) / i + 1;
    assign tab[i] = RCP_W'(Rcp);
  end

  assign rcp = tab[idx];

endmodule

FILE: design/mord_chan.sv
// mord_chan: eight-stage quantise-and-dither pipeline for one colour channel
// depends on mord_pkg and mord_recip
module mord_chan
  import mord_pkg::*;
(
  input  logic             clk,
  input  chan_in_t         din,
  output logic [PIX_W-1:0] dout
);

  localparam int X_W   = 16;
  localparam int P_W   = X_W + RCP_W;
  localparam int NUM_W = PIX_W + 6;
  localparam int E_W   = NUM_W + RCP_W;

  // stage 1: clamp level count
  logic [PIX_W-1:0] c1_r, m1_r, m1_nxt;
  logic [TH_W-1:0]  th1_r;
  // stage 2: scaled index numerator, reciprocal of m
  logic [PIX_W-1:0] c2_r;
  logic [TH_W-1:0]  th2_r;
  logic [X_W-1:0]   x2_r, x2_nxt;
  logic [RCP_W-1:0] rm2_r, rm_rom;
  logic [X_W:0]     xt;
  // stage 3: level index k
  logic [PIX_W-1:0] c3_r, k3_r, k3_nxt;
  logic [TH_W-1:0]  th3_r;
  logic [RCP_W-1:0] rm3_r;
  logic [X_W+K255_W-1:0] kp;
  // stage 4: products for lo and hi
  logic [PIX_W-1:0] c4_r;
  logic [TH_W-1:0]  th4_r;
  logic [X_W-1:0]   a0, a1;
  logic [P_W-1:0]   plo4_r, phi4_r;
  // stage 5: lo, hi, distance
  logic [PIX_W-1:0] c5_r, lo5_r, hi5_r, d5_r, lo5_nxt, hi5_nxt;
  logic [TH_W-1:0]  th5_r;
  logic [NUM_W-1:0] num5_r;
  // stage 6: reciprocal of distance
  logic [PIX_W-1:0] c6_r, lo6_r, hi6_r;
  logic [TH_W-1:0]  th6_r;
  logic [NUM_W-1:0] num6_r;
  logic [RCP_W-1:0] rd6_r, rd_rom;
  // stage 7: extra product
  logic [PIX_W-1:0] c7_r, lo7_r, hi7_r;
  logic [TH_W-1:0]  th7_r;
  logic [E_W-1:0]   pe7_r;
  // stage 8: decision
  logic [TH_W-1:0]  extra;
  logic [PIX_W-1:0] out8_r, out8_nxt;

  always_comb begin
    if (din.levels < LEVELS_W'(2)) begin
      m1_nxt = PIX_W'(1);
    end else if (din.levels > LEVELS_W'(256)) begin
      m1_nxt = PIX_W'(255);
    end else begin
      m1_nxt = PIX_W'(din.levels - LEVELS_W'(1));
    end
  end

  // (c+1)*m - 1, never below zero since m is at least one
  assign xt     = (17'(c1_r) + 17'd1) * 17'(m1_r);
  assign x2_nxt = X_W'(xt - 17'd1);

  mord_recip u_rcp_m (.idx(m1_r), .rcp(rm_rom));

  // k = x / 255 by reciprocal
  assign kp     = (X_W+K255_W)'(x2_r) * (X_W+K255_W)'(K255);
  assign k3_nxt = kp[RCP_SHIFT +: PIX_W];

  assign a0 = {k3_r, 8'd0} - {8'd0, k3_r};
  assign a1 = a0 + X_W'(255);

  assign lo5_nxt = plo4_r[RCP_SHIFT +: PIX_W];
  assign hi5_nxt = phi4_r[RCP_SHIFT +: PIX_W];

  mord_recip u_rcp_d (.idx(d5_r), .rcp(rd_rom));

  assign extra = pe7_r[RCP_SHIFT +: TH_W];

  always_comb begin
    if (c7_r == '1) begin
      out8_nxt = '1;
    end else if (extra > th7_r) begin
      out8_nxt = hi7_r;
    end else begin
      out8_nxt = lo7_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r   <= din.pix;
    m1_r   <= m1_nxt;
    th1_r  <= din.th;

    c2_r   <= c1_r;
    th2_r  <= th1_r;
    x2_r   <= x2_nxt;
    rm2_r  <= rm_rom;

    c3_r   <= c2_r;
    th3_r  <= th2_r;
    k3_r   <= k3_nxt;
    rm3_r  <= rm2_r;

    c4_r   <= c3_r;
    th4_r  <= th3_r;
    plo4_r <= P_W'(a0) * P_W'(rm3_r);
    phi4_r <= P_W'(a1) * P_W'(rm3_r);

    c5_r   <= c4_r;
    th5_r  <= th4_r;
    lo5_r  <= lo5_nxt;
    hi5_r  <= hi5_nxt;
    d5_r   <= hi5_nxt - lo5_nxt;
    num5_r <= {c4_r - lo5_nxt, 6'd0};

    c6_r   <= c5_r;
    th6_r  <= th5_r;
    lo6_r  <= lo5_r;
    hi6_r  <= hi5_r;
    num6_r <= num5_r;
    rd6_r  <= rd_rom;

    c7_r   <= c6_r;
    th7_r  <= th6_r;
    lo7_r  <= lo6_r;
    hi7_r  <= hi6_r;
    pe7_r  <= E_W'(num6_r) * E_W'(rd6_r);

    out8_r <= out8_nxt;
  end

  assign dout = out8_r;

endmodule

FILE: design/multilevel_ordered_dither_rgb.sv
// multilevel_ordered_dither_rgb: top level, config registers, valid pipeline, three channels
// depends on mord_pkg and mord_chan
//
// usage:
//   an item (one rgb pixel with row and column phase and a row-end flag) is
//   taken at a rising edge with start high and busy low. busy is low except
//   while rst_n is held low, so a pixel can be offered in every cycle.
//   each channel is quantised to its configured number of levels and then
//   dithered against an 8x8 threshold matrix picked by the phases.
//   the result appears on the out_ ports with out_valid high for exactly one
//   cycle once the item has passed every stage; results leave in input order.
//   throughput is one item per clock outside reset: every stage of the eight-stage
//   pipeline advances in every cycle, and the receiver cannot stall it.
//   the level counts are written through cfg_we / cfg_index / cfg_data while
//   no item is in flight; index 0 is red, 1 green, 2 blue, others are ignored.
//   reset (synchronous, rst_n low) sets every level count to 2 and drops any
//   items in flight; nothing is emitted for them.
module multilevel_ordered_dither_rgb
  import mord_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [PIX_W-1:0]    in_red_in,
  input  logic [PIX_W-1:0]    in_green_in,
  input  logic [PIX_W-1:0]    in_blue_in,
  input  logic [PHASE_W-1:0]  in_row_phase,
  input  logic [PHASE_W-1:0]  in_col_phase,
  input  logic                in_row_end,
  output logic                out_valid,
  output logic [PIX_W-1:0]    out_red_out,
  output logic [PIX_W-1:0]    out_green_out,
  output logic [PIX_W-1:0]    out_blue_out,
  output logic                out_row_end_out,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [LEVELS_W-1:0] cfg_data
);

  logic [LEVELS_W-1:0] red_levels_r, green_levels_r, blue_levels_r;
  logic [LEVELS_W-1:0] red_levels_nxt, green_levels_nxt, blue_levels_nxt;
  logic [LAT-1:0]      vld_r, vld_nxt;
  logic                re_r [LAT];
  logic                accept;
  logic [TH_W-1:0]     th;
  chan_in_t            red_in, green_in, blue_in;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_comb begin
    red_levels_nxt   = red_levels_r;
    green_levels_nxt = green_levels_r;
    blue_levels_nxt  = blue_levels_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_RED:   red_levels_nxt   = cfg_data;
        REG_GREEN: green_levels_nxt = cfg_data;
        REG_BLUE:  blue_levels_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_levels_r   <= LEVELS_W'(2);
      green_levels_r <= LEVELS_W'(2);
      blue_levels_r  <= LEVELS_W'(2);
      vld_r          <= '0;
    end else begin
      red_levels_r   <= red_levels_nxt;
      green_levels_r <= green_levels_nxt;
      blue_levels_r  <= blue_levels_nxt;
      vld_r          <= vld_nxt;
    end
  end

  assign vld_nxt = {vld_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    re_r[0] <= in_row_end;
    for (int i = 1; i < LAT; i++) begin
      re_r[i] <= re_r[i-1];
    end
  end

  // matrix column is mirrored: 7 - col is the bitwise complement of a 3-bit phase
  assign th = DMAT[in_row_phase][~in_col_phase];

  assign red_in   = '{pix: in_red_in,   levels: red_levels_r,   th: th};
  assign green_in = '{pix: in_green_in, levels: green_levels_r, th: th};
  assign blue_in  = '{pix: in_blue_in,  levels: blue_levels_r,  th: th};

  mord_chan u_red   (.clk(clk), .din(red_in),   .dout(out_red_out));
  mord_chan u_green (.clk(clk), .din(green_in), .dout(out_green_out));
  mord_chan u_blue  (.clk(clk), .din(blue_in),  .dout(out_blue_out));

  assign out_valid       = vld_r[LAT-1];
  assign out_row_end_out = re_r[LAT-1];

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted item gave no result after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted item");

  a_row_end_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_end_out == $past(in_row_end, LAT))
    else $error("row end flag not aligned with its item");

  a_full_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_red_in, LAT) == 8'hFF |-> out_red_out == 8'hFF)
    else $error("full red intensity not kept at full scale");

endmodule
